@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/spkh_pkg.sv @@
// Package with the constants, types and control struct of the keyed byte hash.
package spkh_pkg;

  localparam int unsigned ROUNDS      = 32;
  localparam int unsigned ROT_X       = 8;
  localparam int unsigned ROT_Y       = 3;
  localparam int unsigned BLOCK_BYTES = 16;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned RND_W       = $clog2(ROUNDS);
  localparam int unsigned CNT_W       = $clog2(BLOCK_BYTES);
  localparam int unsigned CFG_IDX_W   = 1;

  typedef logic [WORD_W-1:0] word_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_LOW  = 1'b0,
    REG_KEY_HIGH = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ENC,
    ST_FOLD,
    ST_EMIT
  } state_t;

  // Controls from the sequencer to the datapath.
  typedef struct packed {
    logic             in_ready;
    logic             accept;
    logic [CNT_W-1:0] byte_pos;
    logic             start;
    logic             round_en;
    logic [RND_W-1:0] round_idx;
    logic             fold;
    logic             emit;
  } ctl_t;

endpackage

@@ hw/rtl/spkh_round.sv @@
// One Speck128 round on the data words together with one key schedule round.
module spkh_round (
  input  spkh_pkg::word_t               x_in,
  input  spkh_pkg::word_t               y_in,
  input  spkh_pkg::word_t               ka_in,
  input  spkh_pkg::word_t               kb_in,
  input  logic [spkh_pkg::RND_W-1:0]    round_idx,
  output spkh_pkg::word_t               x_out,
  output spkh_pkg::word_t               y_out,
  output spkh_pkg::word_t               ka_out,
  output spkh_pkg::word_t               kb_out
);

  spkh_pkg::word_t x_rot;
  spkh_pkg::word_t kb_rot;
  spkh_pkg::word_t rnd_word;

  assign x_rot    = {x_in[spkh_pkg::ROT_X-1:0], x_in[spkh_pkg::WORD_W-1:spkh_pkg::ROT_X]};
  assign kb_rot   = {kb_in[spkh_pkg::ROT_X-1:0], kb_in[spkh_pkg::WORD_W-1:spkh_pkg::ROT_X]};
  assign rnd_word = {{(spkh_pkg::WORD_W-spkh_pkg::RND_W){1'b0}}, round_idx};

  // The data round is keyed with the schedule word before it is advanced.
  assign x_out  = (x_rot + y_in) ^ ka_in;
  assign y_out  = {y_in[spkh_pkg::WORD_W-spkh_pkg::ROT_Y-1:0],
                   y_in[spkh_pkg::WORD_W-1:spkh_pkg::WORD_W-spkh_pkg::ROT_Y]} ^ x_out;
  assign kb_out = (kb_rot + ka_in) ^ rnd_word;
  assign ka_out = {ka_in[spkh_pkg::WORD_W-spkh_pkg::ROT_Y-1:0],
                   ka_in[spkh_pkg::WORD_W-1:spkh_pkg::WORD_W-spkh_pkg::ROT_Y]} ^ kb_out;

endmodule

@@ hw/rtl/spkh_ctrl.sv @@
// Sequencer: byte position, round counter and the states of one block.
module spkh_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_last_byte,
  input  logic           out_valid,
  input  logic           out_ready,
  output spkh_pkg::ctl_t ctl
);

  spkh_pkg::state_t                state_r, state_nxt;
  logic [spkh_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [spkh_pkg::RND_W-1:0]      rnd_r, rnd_nxt;
  logic                            final_r, final_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spkh_pkg::ST_IDLE;
      cnt_r   <= '0;
      rnd_r   <= '0;
      final_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rnd_r   <= rnd_nxt;
      final_r <= final_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rnd_nxt       = rnd_r;
    final_nxt     = final_r;
    ctl           = '0;
    ctl.byte_pos  = cnt_r;
    ctl.round_idx = rnd_r;
    case (state_r)
      spkh_pkg::ST_IDLE: begin
        ctl.in_ready = 1'b1;
        if (in_valid) begin
          ctl.accept = 1'b1;
          // A full block wraps the count back to zero by itself.
          cnt_nxt    = cnt_r + 1'b1;
          if (cnt_r == spkh_pkg::CNT_W'(spkh_pkg::BLOCK_BYTES - 1) || in_last_byte) begin
            ctl.start = 1'b1;
            rnd_nxt   = '0;
            final_nxt = in_last_byte;
            state_nxt = spkh_pkg::ST_ENC;
          end
        end
      end
      spkh_pkg::ST_ENC: begin
        ctl.round_en = 1'b1;
        rnd_nxt      = rnd_r + 1'b1;
        if (rnd_r == spkh_pkg::RND_W'(spkh_pkg::ROUNDS - 1)) begin
          state_nxt = spkh_pkg::ST_FOLD;
        end
      end
      spkh_pkg::ST_FOLD: begin
        ctl.fold  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = final_r ? spkh_pkg::ST_EMIT : spkh_pkg::ST_IDLE;
      end
      spkh_pkg::ST_EMIT: begin
        // Wait until the output register is free or being emptied.
        if (!out_valid || out_ready) begin
          ctl.emit  = 1'b1;
          final_nxt = 1'b0;
          state_nxt = spkh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = spkh_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/speck128_keyed_byte_hash_unit.sv @@
// Top level of the Speck128/128 keyed byte hash: key registers, block buffer and datapath.
//
// Message bytes enter on the in_ channel (valid/ready), one byte per word, with
// in_last_byte set on the final byte of a message. The 64-bit hash leaves on the
// out_ channel (valid/ready) once per message. The cfg_ port writes the two key
// words; a block is encrypted with the key as it stands when that block starts.
// A byte that neither fills a block nor ends the message is stored in the block
// buffer. A byte that fills the 16-byte block or ends the message starts an
// encryption: the single round unit runs one round per cycle through all rounds,
// then a fold step XORs both block words into the accumulator. After the fold
// of a final block, an emit step moves the hash into the output register once
// that register is free or being emptied. The output register lets the next
// message start while a hash waits; if a new hash is due while the previous
// one is still stalled, the block holds in_ready low until the receiver takes
// the old one. Reset clears the keys, the block buffer, the byte count, the
// accumulator and the output valid.
module speck128_keyed_byte_hash_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [spkh_pkg::BYTE_W-1:0]          in_data_byte,
  input  logic                                 in_last_byte,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [spkh_pkg::WORD_W-1:0]          out_hash_value,
  input  logic                                 cfg_we,
  input  logic [spkh_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [spkh_pkg::WORD_W-1:0]          cfg_data
);

  spkh_pkg::ctl_t                  ctl;
  spkh_pkg::word_t                 key_low_r, key_low_nxt;
  spkh_pkg::word_t                 key_high_r, key_high_nxt;
  logic [2*spkh_pkg::WORD_W-1:0]   blk_r, blk_nxt;
  spkh_pkg::word_t                 acc_r, acc_nxt;
  spkh_pkg::word_t                 ka_r, ka_nxt;
  spkh_pkg::word_t                 kb_r, kb_nxt;
  spkh_pkg::word_t                 out_hash_r, out_hash_nxt;
  logic                            out_valid_r, out_valid_nxt;
  spkh_pkg::word_t                 x_new, y_new, ka_new, kb_new;

  spkh_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid_r),
    .out_ready    (out_ready),
    .ctl          (ctl)
  );

  // Low word of the block is the Speck y word, high word the x word.
  spkh_round u_round (
    .x_in      (blk_r[2*spkh_pkg::WORD_W-1:spkh_pkg::WORD_W]),
    .y_in      (blk_r[spkh_pkg::WORD_W-1:0]),
    .ka_in     (ka_r),
    .kb_in     (kb_r),
    .round_idx (ctl.round_idx),
    .x_out     (x_new),
    .y_out     (y_new),
    .ka_out    (ka_new),
    .kb_out    (kb_new)
  );

  always_comb begin
    key_low_nxt   = key_low_r;
    key_high_nxt  = key_high_r;
    blk_nxt       = blk_r;
    acc_nxt       = acc_r;
    ka_nxt        = ka_r;
    kb_nxt        = kb_r;
    out_hash_nxt  = out_hash_r;
    out_valid_nxt = out_valid_r;

    if (cfg_we) begin
      case (cfg_index)
        spkh_pkg::REG_KEY_LOW:  key_low_nxt  = cfg_data;
        spkh_pkg::REG_KEY_HIGH: key_high_nxt = cfg_data;
        default: ;
      endcase
    end

    if (ctl.accept) begin
      blk_nxt[{ctl.byte_pos, 3'b000} +: spkh_pkg::BYTE_W] = in_data_byte;
    end
    if (ctl.start) begin
      ka_nxt = key_low_r;
      kb_nxt = key_high_r;
    end
    if (ctl.round_en) begin
      blk_nxt = {x_new, y_new};
      ka_nxt  = ka_new;
      kb_nxt  = kb_new;
    end
    if (ctl.fold) begin
      acc_nxt = acc_r ^ blk_r[spkh_pkg::WORD_W-1:0]
                      ^ blk_r[2*spkh_pkg::WORD_W-1:spkh_pkg::WORD_W];
      blk_nxt = '0;
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctl.emit) begin
      out_hash_nxt  = acc_r;
      out_valid_nxt = 1'b1;
      acc_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r   <= '0;
      key_high_r  <= '0;
      blk_r       <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      key_low_r   <= key_low_nxt;
      key_high_r  <= key_high_nxt;
      blk_r       <= blk_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ka_r       <= ka_nxt;
    kb_r       <= kb_nxt;
    out_hash_r <= out_hash_nxt;
  end

  assign in_ready       = ctl.in_ready;
  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

endmodule

@@ hw/rtl/spkh_checker.sv @@
// Port-level checker for the keyed byte hash, bound to the top level.
`include "assert_macros.svh"

module spkh_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_last_byte,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [spkh_pkg::WORD_W-1:0]   out_hash_value
);

  // A stalled hash word stays offered.
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "out_valid dropped while stalled")

  // A stalled hash word keeps its value.
  `ASSERT_CLK(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_hash_value), "hash changed while stalled")

  // Taking the final byte starts an encryption, so the input closes next cycle.
  `ASSERT_CLK(a_last_busy, clk, rst_n, in_valid && in_ready && in_last_byte |=> !in_ready, "input open after final byte")

  // The round unit needs many cycles, so a hash never follows the final byte at once.
  `ASSERT_CLK(a_no_early_hash, clk, rst_n, in_valid && in_ready && in_last_byte |=> !$rose(out_valid), "hash shown too early")

  // Reset empties the output register.
  `ASSERT_CLK_ALWAYS(a_reset_out, clk, !rst_n |=> !out_valid, "out_valid set after reset")

endmodule

bind speck128_keyed_byte_hash_unit spkh_checker u_spkh_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_last_byte   (in_last_byte),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_hash_value (out_hash_value)
);
